// File: src/pld3_pkg.sv
// ----------------------------------------------------------------------------
// pld3_pkg
// Shared types and constants for the point to line distance core.
// ----------------------------------------------------------------------------
package pld3_pkg;

  localparam int DIST_WIDTH = 21;
  localparam int QUOT_WIDTH = 2 * DIST_WIDTH;

  // side information that travels with each request down the chain
  typedef struct packed {
    logic valid;
    logic degen;
    logic sat;
  } pld3_tag_t;

endpackage

// File: src/point_line_distance_3d_core.sv
// ----------------------------------------------------------------------------
// point_line_distance_3d_core
// Perpendicular distance from a probe point to the line through two points.
// ----------------------------------------------------------------------------
// pipeline: request to done passes the front stages, one divide cell per quotient
//   bit, one root cell per bit and the output register
// throughput: one request per cycle, busy is always low
// reset: synchronous, clears all valid bits; the receiver cannot stall
module point_line_distance_3d_core import pld3_pkg::*; #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] line_a_x,
  input  logic signed [COORD_WIDTH-1:0] line_a_y,
  input  logic signed [COORD_WIDTH-1:0] line_a_z,
  input  logic signed [COORD_WIDTH-1:0] line_b_x,
  input  logic signed [COORD_WIDTH-1:0] line_b_y,
  input  logic signed [COORD_WIDTH-1:0] line_b_z,
  input  logic signed [COORD_WIDTH-1:0] probe_x,
  input  logic signed [COORD_WIDTH-1:0] probe_y,
  input  logic signed [COORD_WIDTH-1:0] probe_z,
  output logic                          done,
  output logic [DIST_WIDTH-1:0]         distance_scaled,
  output logic                          degenerate_line
);

  localparam int RW = 2 * (COORD_WIDTH + 1);

  logic [RW-1:0]         d_rem  [QUOT_WIDTH+1];
  logic [QUOT_WIDTH-1:0] d_work [QUOT_WIDTH+1];
  logic [RW-1:0]         d_den  [QUOT_WIDTH+1];
  pld3_tag_t             d_tag  [QUOT_WIDTH+1];

  logic [DIST_WIDTH:0]   s_rem  [DIST_WIDTH+1];
  logic [DIST_WIDTH-1:0] s_root [DIST_WIDTH+1];
  logic [QUOT_WIDTH-1:0] s_val  [DIST_WIDTH+1];
  pld3_tag_t             s_tag  [DIST_WIDTH+1];

  assign busy = 1'b0;

  pld3_front #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .RW            (RW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .line_a_x (line_a_x),
    .line_a_y (line_a_y),
    .line_a_z (line_a_z),
    .line_b_x (line_b_x),
    .line_b_y (line_b_y),
    .line_b_z (line_b_z),
    .probe_x  (probe_x),
    .probe_y  (probe_y),
    .probe_z  (probe_z),
    .rem_out  (d_rem[0]),
    .work_out (d_work[0]),
    .den_out  (d_den[0]),
    .tag_out  (d_tag[0])
  );

  for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_div
    pld3_div_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .rem_in   (d_rem[i]),
      .work_in  (d_work[i]),
      .den_in   (d_den[i]),
      .tag_in   (d_tag[i]),
      .rem_out  (d_rem[i+1]),
      .work_out (d_work[i+1]),
      .den_out  (d_den[i+1]),
      .tag_out  (d_tag[i+1])
    );
  end

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_val[0]  = d_work[QUOT_WIDTH];
  assign s_tag[0]  = d_tag[QUOT_WIDTH];

  for (genvar i = 0; i < DIST_WIDTH; i++) begin : g_sqrt
    pld3_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rem_in   (s_rem[i]),
      .root_in  (s_root[i]),
      .val_in   (s_val[i]),
      .tag_in   (s_tag[i]),
      .rem_out  (s_rem[i+1]),
      .root_out (s_root[i+1]),
      .val_out  (s_val[i+1]),
      .tag_out  (s_tag[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_tag[DIST_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    degenerate_line <= s_tag[DIST_WIDTH].degen;
    if (s_tag[DIST_WIDTH].degen) begin
      distance_scaled <= '0;
    end else if (s_tag[DIST_WIDTH].sat) begin
      distance_scaled <= '1;
    end else begin
      distance_scaled <= s_root[DIST_WIDTH];
    end
  end

endmodule

// File: src/pld3_front.sv
// ----------------------------------------------------------------------------
// pld3_front
// Differences, cross product, squared lengths and the divide setup.
// ----------------------------------------------------------------------------
module pld3_front import pld3_pkg::*; #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 4,
  parameter int RW            = 2 * (COORD_WIDTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] line_a_x,
  input  logic signed [COORD_WIDTH-1:0] line_a_y,
  input  logic signed [COORD_WIDTH-1:0] line_a_z,
  input  logic signed [COORD_WIDTH-1:0] line_b_x,
  input  logic signed [COORD_WIDTH-1:0] line_b_y,
  input  logic signed [COORD_WIDTH-1:0] line_b_z,
  input  logic signed [COORD_WIDTH-1:0] probe_x,
  input  logic signed [COORD_WIDTH-1:0] probe_y,
  input  logic signed [COORD_WIDTH-1:0] probe_z,
  output logic [RW-1:0]                 rem_out,
  output logic [QUOT_WIDTH-1:0]         work_out,
  output logic [RW-1:0]                 den_out,
  output pld3_tag_t                     tag_out
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = 4 * DW;
  localparam int NW  = SW + 2 + 2 * FRACTION_BITS;
  localparam int NPW = (NW > QUOT_WIDTH + RW) ? NW : QUOT_WIDTH + RW;

  // stage 1: difference vectors
  logic                 v1;
  logic signed [DW-1:0] abx, aby, abz, acx, acy, acz;
  // stage 2: products
  logic                 v2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5, d0, d1, d2;
  // stage 3: cross magnitudes and squared length
  logic                 v3;
  logic [PW-1:0]        m0, m1, m2;
  logic [RW-1:0]        den3;
  // stage 4: squares
  logic                 v4;
  logic [SW-1:0]        q0, q1, q2;
  logic [RW-1:0]        den4;

  logic signed [PW:0]   c0, c1, c2;
  logic [PW-1:0]        m0_next, m1_next, m2_next;
  logic [SW+1:0]        num_sum;
  logic [NPW-1:0]       num_pad;

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [COORD_WIDTH-1:0] b,
                                                   input logic signed [COORD_WIDTH-1:0] a);
    sub_ext = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      tag_out.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      tag_out.valid <= v4;
    end
  end

  always_comb begin
    c0 = {p0[PW-1], p0} - {p1[PW-1], p1};
    c1 = {p2[PW-1], p2} - {p3[PW-1], p3};
    c2 = {p4[PW-1], p4} - {p5[PW-1], p5};
    m0_next = c0[PW] ? PW'(-c0) : c0[PW-1:0];
    m1_next = c1[PW] ? PW'(-c1) : c1[PW-1:0];
    m2_next = c2[PW] ? PW'(-c2) : c2[PW-1:0];
    num_sum = (SW + 2)'(q0) + (SW + 2)'(q1) + (SW + 2)'(q2);
    num_pad = NPW'(num_sum) << (2 * FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    abx <= sub_ext(line_b_x, line_a_x);
    aby <= sub_ext(line_b_y, line_a_y);
    abz <= sub_ext(line_b_z, line_a_z);
    acx <= sub_ext(probe_x, line_a_x);
    acy <= sub_ext(probe_y, line_a_y);
    acz <= sub_ext(probe_z, line_a_z);

    p0 <= aby * acz;
    p1 <= abz * acy;
    p2 <= abz * acx;
    p3 <= abx * acz;
    p4 <= abx * acy;
    p5 <= aby * acx;
    d0 <= abx * abx;
    d1 <= aby * aby;
    d2 <= abz * abz;

    m0   <= m0_next;
    m1   <= m1_next;
    m2   <= m2_next;
    den3 <= RW'($unsigned(d0)) + RW'($unsigned(d1)) + RW'($unsigned(d2));

    q0   <= SW'(m0) * SW'(m0);
    q1   <= SW'(m1) * SW'(m1);
    q2   <= SW'(m2) * SW'(m2);
    den4 <= den3;

    // quotient would not fit in the chain: answer saturates
    tag_out.sat   <= num_pad[NPW-1:QUOT_WIDTH] >= (NPW - QUOT_WIDTH)'(den4);
    tag_out.degen <= den4 == '0;
    rem_out       <= num_pad[QUOT_WIDTH+RW-1:QUOT_WIDTH];
    work_out      <= num_pad[QUOT_WIDTH-1:0];
    den_out       <= den4;
  end

endmodule

// File: src/pld3_div_cell.sv
// ----------------------------------------------------------------------------
// pld3_div_cell
// One restoring divide step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module pld3_div_cell import pld3_pkg::*; #(
  parameter int RW = 34
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RW-1:0]         rem_in,
  input  logic [QUOT_WIDTH-1:0] work_in,
  input  logic [RW-1:0]         den_in,
  input  pld3_tag_t             tag_in,
  output logic [RW-1:0]         rem_out,
  output logic [QUOT_WIDTH-1:0] work_out,
  output logic [RW-1:0]         den_out,
  output pld3_tag_t             tag_out
);

  logic [RW:0] trial;
  logic        ge;
  logic [RW:0] diff;

  always_comb begin
    trial = {rem_in, work_in[QUOT_WIDTH-1]};
    ge    = trial >= {1'b0, den_in};
    diff  = trial - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_out.degen <= tag_in.degen;
    tag_out.sat   <= tag_in.sat;
    // numerator bits leave at the top, quotient bits enter at the bottom
    work_out      <= {work_in[QUOT_WIDTH-2:0], ge};
    rem_out       <= ge ? diff[RW-1:0] : trial[RW-1:0];
    den_out       <= den_in;
  end

endmodule

// File: src/pld3_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pld3_sqrt_cell
// One restoring square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module pld3_sqrt_cell import pld3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DIST_WIDTH:0]   rem_in,
  input  logic [DIST_WIDTH-1:0] root_in,
  input  logic [QUOT_WIDTH-1:0] val_in,
  input  pld3_tag_t             tag_in,
  output logic [DIST_WIDTH:0]   rem_out,
  output logic [DIST_WIDTH-1:0] root_out,
  output logic [QUOT_WIDTH-1:0] val_out,
  output pld3_tag_t             tag_out
);

  logic [DIST_WIDTH+2:0] acc;
  logic [DIST_WIDTH+2:0] cand;
  logic                  ge;
  logic [DIST_WIDTH+2:0] diff;

  always_comb begin
    acc  = {rem_in, val_in[QUOT_WIDTH-1:QUOT_WIDTH-2]};
    cand = {1'b0, root_in, 2'b01};
    ge   = acc >= cand;
    diff = acc - cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_out.degen <= tag_in.degen;
    tag_out.sat   <= tag_in.sat;
    val_out       <= {val_in[QUOT_WIDTH-3:0], 2'b00};
    root_out      <= {root_in[DIST_WIDTH-2:0], ge};
    rem_out       <= ge ? diff[DIST_WIDTH:0] : acc[DIST_WIDTH:0];
  end

endmodule
